// ===== sv/dpr_pkg.sv =====
// Package for the depth pixel reprojection unit.
// Shared register indexes, field helpers, pipeline sizes and inter-stage types.
`timescale 1ns / 1ps
package dpr_pkg;

    localparam int REG_COUNT  = 7;
    // Divider: one entry stage plus 16 stages of two quotient bits each
    localparam int DIV_STAGES = 17;

    typedef enum logic [2:0] {
        REG_BP0  = 3'd0,
        REG_BP1  = 3'd1,
        REG_BP2  = 3'd2,
        REG_TRAN = 3'd3,
        REG_K0   = 3'd4,
        REG_K1   = 3'd5,
        REG_K2   = 3'd6,
        REG_NONE = 3'd7
    } reg_idx_t;

    typedef logic [62:0] reg_word_t;

    // Coefficient k of a packed register, sign extended
    function automatic logic signed [20:0] coef(input reg_word_t r, input int k);
        coef = r[21*k +: 21];
    endfunction

    // Clip to signed 32 bits, flags clipping
    function automatic logic signed [31:0] clip32(input logic signed [63:0] x,
                                                  output logic sat);
        sat = 1'b0;
        if (x > 64'sd2147483647) begin
            sat = 1'b1;
            clip32 = 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            sat = 1'b1;
            clip32 = 32'sh80000000;
        end else begin
            clip32 = x[31:0];
        end
    endfunction

    // Result item handed between stages
    typedef struct packed {
        logic              ok;
        logic signed [31:0] ix;
        logic signed [31:0] iy;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic              sat;
    } res_t;

endpackage

// ===== sv/dpr_divider.sv =====
// Pipelined Q16.16 divider for both image coordinates.
// Uses dpr_pkg. Entry stage plus two quotient bits per stage, item per cycle while en.
`timescale 1ns / 1ps
module dpr_divider
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [63:0]         num_x,      // magnitudes, < 2^62
    input  logic [63:0]         num_y,
    input  logic [63:0]         den,
    input  logic                neg_x,
    input  logic                neg_y,
    input  logic                zero_den,
    input  logic                nz_x,       // numerator nonzero
    input  logic                nz_y,
    input  dpr_pkg::res_t       side_in,
    output logic                out_valid,
    output dpr_pkg::res_t       res_out
);
    import dpr_pkg::*;

    // Stage 0 resolves the integer part: quotient >= 2^16 overflows.
    // Stages 1..16 produce quotient bits 31..0 of n*2^16/d, two at a time.
    logic [DIV_STAGES-1:0] v_reg;
    logic [63:0]           d_reg   [DIV_STAGES];
    logic [DIV_STAGES-1:0] ox_reg, oy_reg;
    logic [DIV_STAGES-1:0] sx_reg, sy_reg, z_reg, zx_reg, zy_reg;
    res_t                  sd_reg  [DIV_STAGES];
    logic [31:0]           acx_reg [DIV_STAGES];
    logic [31:0]           acy_reg [DIV_STAGES];
    logic [87:0]           rmx_reg [DIV_STAGES];
    logic [87:0]           rmy_reg [DIV_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[DIV_STAGES-2:0], in_valid};
    end

    // Entry compare against den*2^16, then restoring stages MSB first
    always_ff @(posedge clk)
    begin
        logic [87:0] rx, ry, d1, d0;
        logic [31:0] ax, ay;
        if (en)
        begin
            d_reg[0]   <= den;
            ox_reg[0]  <= !zero_den && ({16'd0, num_x} >= {den, 16'd0});
            oy_reg[0]  <= !zero_den && ({16'd0, num_y} >= {den, 16'd0});
            sx_reg[0]  <= neg_x;
            sy_reg[0]  <= neg_y;
            z_reg[0]   <= zero_den;
            zx_reg[0]  <= nz_x;
            zy_reg[0]  <= nz_y;
            sd_reg[0]  <= side_in;
            acx_reg[0] <= '0;
            acy_reg[0] <= '0;
            rmx_reg[0] <= {8'd0, num_x, 16'd0};
            rmy_reg[0] <= {8'd0, num_y, 16'd0};
            for (int s = 0; s < DIV_STAGES - 1; s++)
            begin
                rx = rmx_reg[s];
                ry = rmy_reg[s];
                ax = acx_reg[s];
                ay = acy_reg[s];
                // den < 2^55, so the shifted divisor fits in 88 bits
                d1 = {24'd0, d_reg[s]} << (31 - 2*s);
                d0 = {24'd0, d_reg[s]} << (30 - 2*s);
                if (rx >= d1) begin rx = rx - d1; ax[31-2*s] = 1'b1; end
                if (rx >= d0) begin rx = rx - d0; ax[30-2*s] = 1'b1; end
                if (ry >= d1) begin ry = ry - d1; ay[31-2*s] = 1'b1; end
                if (ry >= d0) begin ry = ry - d0; ay[30-2*s] = 1'b1; end
                rmx_reg[s+1] <= rx;
                rmy_reg[s+1] <= ry;
                acx_reg[s+1] <= ax;
                acy_reg[s+1] <= ay;
                d_reg[s+1]   <= d_reg[s];
                ox_reg[s+1]  <= ox_reg[s];
                oy_reg[s+1]  <= oy_reg[s];
                sx_reg[s+1]  <= sx_reg[s];
                sy_reg[s+1]  <= sy_reg[s];
                z_reg[s+1]   <= z_reg[s];
                zx_reg[s+1]  <= zx_reg[s];
                zy_reg[s+1]  <= zy_reg[s];
                sd_reg[s+1]  <= sd_reg[s];
            end
        end
    end

    // Final sign, clip and zero-denominator handling
    function automatic logic signed [31:0] fin(input logic [31:0] q, input logic ovf,
                                               input logic neg, input logic zd,
                                               input logic nz, output logic sat);
        logic signed [63:0] m;
        logic               s2;
        sat = 1'b0;
        if (zd) begin
            sat = nz;
            fin = !nz ? 32'sd0 : (neg ? 32'sh80000000 : 32'sh7fffffff);
        end else begin
            m = ovf ? 64'sh100000000 : {32'd0, q};
            if (neg) m = -m;
            fin = clip32(m, s2);
            sat = s2;
        end
    endfunction

    logic sxo, syo;
    always_comb
    begin
        res_out     = sd_reg[DIV_STAGES-1];
        res_out.ix  = fin(acx_reg[DIV_STAGES-1], ox_reg[DIV_STAGES-1],
                          sx_reg[DIV_STAGES-1], z_reg[DIV_STAGES-1],
                          zx_reg[DIV_STAGES-1], sxo);
        res_out.iy  = fin(acy_reg[DIV_STAGES-1], oy_reg[DIV_STAGES-1],
                          sy_reg[DIV_STAGES-1], z_reg[DIV_STAGES-1],
                          zy_reg[DIV_STAGES-1], syo);
        res_out.sat = sd_reg[DIV_STAGES-1].sat | sxo | syo | z_reg[DIV_STAGES-1];
        if (!sd_reg[DIV_STAGES-1].ok)
            res_out = '0;
        out_valid   = v_reg[DIV_STAGES-1];
    end

endmodule

// ===== sv/dpr_transform.sv =====
// Back-projection, translation and projection stages.
// Uses dpr_pkg. Six register stages feeding the divider.
`timescale 1ns / 1ps
module dpr_transform
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [11:0]           column,
    input  logic [11:0]           row,
    input  logic signed [31:0]    depth,
    input  dpr_pkg::reg_word_t    regs [dpr_pkg::REG_COUNT],
    output logic                  out_valid,
    output logic [63:0]           num_x,
    output logic [63:0]           num_y,
    output logic [63:0]           den,
    output logic                  neg_x,
    output logic                  neg_y,
    output logic                  zero_den,
    output logic                  nz_x,
    output logic                  nz_y,
    output dpr_pkg::res_t         side
);
    import dpr_pkg::*;

    logic [5:0] v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[4:0], in_valid};
    end

    // S1: fold the coordinates into the coefficients: B[j][0]*u, B[j][1]*v, B[j][2]
    logic signed [33:0] c_reg [3][3];
    logic signed [31:0] z1_reg;
    logic               zpos1_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                c_reg[j][0] <= 34'(coef(regs[j], 0)) * 34'($signed({1'b0, column}));
                c_reg[j][1] <= 34'(coef(regs[j], 1)) * 34'($signed({1'b0, row}));
                c_reg[j][2] <= 34'(coef(regs[j], 2));
            end
            z1_reg    <= depth;
            zpos1_reg <= depth > 0;
        end
    end

    // S2: nine products B[j][i]*p[i], formed as (coefficient term) * z
    logic signed [65:0] m_reg [3][3];
    logic               zpos2_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
                for (int i = 0; i < 3; i++)
                    m_reg[j][i] <= 66'(c_reg[j][i]) * 66'(z1_reg);
            zpos2_reg <= zpos1_reg;
        end
    end

    // S3: sum, floor to Q16.16, add translation; check validity; clip
    logic signed [31:0] ps_reg [3];
    logic               ok3_reg, sat3_reg;
    always_ff @(posedge clk)
    begin
        logic signed [67:0] acc;
        logic signed [63:0] pt;
        logic               s;
        logic               sa;
        logic               pzpos;
        if (en)
        begin
            sa = 1'b0;
            pzpos = 1'b0;
            for (int j = 0; j < 3; j++)
            begin
                acc = 68'(m_reg[j][0]) + 68'(m_reg[j][1]) + 68'(m_reg[j][2]);
                pt = 64'(acc >>> 18) + 64'(coef(regs[REG_TRAN], j)) * 64'sd4;
                if (j == 2) pzpos = pt > 0;
                ps_reg[j] <= clip32(pt, s);
                sa = sa | s;
            end
            ok3_reg  <= zpos2_reg && pzpos;
            sat3_reg <= sa;
        end
    end

    // S4: nine products K[j][i]*ps[i]
    logic signed [52:0] k_reg [3][3];
    logic signed [31:0] ps4_reg [3];
    logic               ok4_reg, sat4_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
                for (int i = 0; i < 3; i++)
                    k_reg[j][i] <= coef(regs[REG_K0 + j], i) * ps_reg[i];
            ps4_reg  <= ps_reg;
            ok4_reg  <= ok3_reg;
            sat4_reg <= sat3_reg;
        end
    end

    // S5: q sums
    logic signed [54:0] q_reg [3];
    logic signed [31:0] ps5_reg [3];
    logic               ok5_reg, sat5_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
                q_reg[j] <= 55'(k_reg[j][0]) + 55'(k_reg[j][1]) + 55'(k_reg[j][2]);
            ps5_reg  <= ps4_reg;
            ok5_reg  <= ok4_reg;
            sat5_reg <= sat4_reg;
        end
    end

    // S6: magnitudes and signs for the divider
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_x    <= q_reg[0] < 0 ? 64'(-q_reg[0]) : 64'(q_reg[0]);
            num_y    <= q_reg[1] < 0 ? 64'(-q_reg[1]) : 64'(q_reg[1]);
            den      <= q_reg[2] < 0 ? 64'(-q_reg[2]) : 64'(q_reg[2]);
            zero_den <= q_reg[2] == 0;
            neg_x    <= q_reg[2] == 0 ? q_reg[0] < 0 : (q_reg[0] < 0) != (q_reg[2] < 0);
            neg_y    <= q_reg[2] == 0 ? q_reg[1] < 0 : (q_reg[1] < 0) != (q_reg[2] < 0);
            nz_x     <= q_reg[0] != 0;
            nz_y     <= q_reg[1] != 0;
            side.ok  <= ok5_reg;
            side.ix  <= '0;
            side.iy  <= '0;
            side.px  <= ps5_reg[0];
            side.py  <= ps5_reg[1];
            side.pz  <= ps5_reg[2];
            side.sat <= sat5_reg;
        end
    end

    assign out_valid = v_reg[5];

endmodule

// ===== sv/depth_pixel_reprojection_unit.sv =====
// Top level of the depth pixel reprojection unit.
// Uses dpr_pkg, dpr_transform and dpr_divider; holds the config registers.
//
//  channel | dir | payload
//  s_axis  | in  | tdata: column[11:0], row[23:12], depth[55:24]
//  m_axis  | out | tdata: image_x, image_y, point_x, point_y, point_z; tuser: valid_res, saturated
//  cfg     | in  | cfg_index[2:0], cfg_data[62:0]
//
// One pixel per cycle while the pipeline is not stalled; a taken request passes through
// 6 transform stages, 17 divider stages, then the output register to reach m_axis.
// The whole pipeline advances together; it stalls only when a result arrives while
// the output is held, and that result waits in a skid register until the output moves.
// Reset loads identity matrices and zero translation and empties the pipeline.
`timescale 1ns / 1ps
module depth_pixel_reprojection_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [55:0]  s_axis_tdata,   // column, row, depth
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,   // image_x, image_y, point_x, point_y, point_z
    output logic [1:0]   m_axis_tuser,   // valid_res, saturated
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [62:0]  cfg_data
);
    import dpr_pkg::*;

    reg_word_t regs_reg [REG_COUNT];

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg[REG_BP0]  <= 63'd262144;
            regs_reg[REG_BP1]  <= 63'd549755813888;
            regs_reg[REG_BP2]  <= 63'd1152921504606846976;
            regs_reg[REG_TRAN] <= 63'd0;
            regs_reg[REG_K0]   <= 63'd256;
            regs_reg[REG_K1]   <= 63'd536870912;
            regs_reg[REG_K2]   <= 63'd1125899906842624;
        end
        else if (cfg_valid && cfg_index != REG_NONE)
        begin
            regs_reg[cfg_index] <= cfg_data;
        end
    end

    // Output register and skid buffer; pipeline runs while skid empty
    logic  out_v_reg, skid_v_reg, en;
    res_t  out_reg, skid_reg, pipe_res;
    logic  pipe_v;

    assign en            = !skid_v_reg;
    assign s_axis_tready = en;

    logic        t_v, nxz, nyz, nx_neg, ny_neg, zd;
    logic [63:0] nx, ny, dn;
    res_t        side;

    dpr_transform u_tr
    (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s_axis_tvalid),
        .column(s_axis_tdata[11:0]), .row(s_axis_tdata[23:12]),
        .depth(s_axis_tdata[55:24]), .regs(regs_reg),
        .out_valid(t_v), .num_x(nx), .num_y(ny), .den(dn),
        .neg_x(nx_neg), .neg_y(ny_neg), .zero_den(zd), .nz_x(nxz), .nz_y(nyz),
        .side(side)
    );

    dpr_divider u_div
    (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(t_v),
        .num_x(nx), .num_y(ny), .den(dn), .neg_x(nx_neg), .neg_y(ny_neg),
        .zero_den(zd), .nz_x(nxz), .nz_y(nyz), .side_in(side),
        .out_valid(pipe_v), .res_out(pipe_res)
    );

    // Skid fills when a result arrives while the output register is held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            if (!out_v_reg || m_axis_tready)
            begin
                out_v_reg  <= skid_v_reg || (en && pipe_v);
                skid_v_reg <= 1'b0;
            end
            else if (en && pipe_v)
            begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || m_axis_tready)
            out_reg <= skid_v_reg ? skid_reg : pipe_res;
        else if (en && pipe_v)
            skid_reg <= pipe_res;
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {out_reg.pz, out_reg.py, out_reg.px, out_reg.iy, out_reg.ix};
    assign m_axis_tuser  = {out_reg.sat, out_reg.ok};

    // Skid is only occupied while the output is held
    assert property (@(posedge clk) disable iff (!rst_n) skid_v_reg |-> out_v_reg)
        else $error("skid full with empty output");
    // Pipeline frozen while skid full
    assert property (@(posedge clk) disable iff (!rst_n) skid_v_reg |-> !s_axis_tready)
        else $error("input taken with skid full");
    // Invalid result carries no flags
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> !m_axis_tuser[1])
        else $error("invalid pixel flagged saturated");

endmodule

// ===== sim/tb_depth_pixel_reprojection_unit.sv =====
// Self-checking testbench for depth_pixel_reprojection_unit.
// Depends on dpr_pkg and the unit's RTL; predicts each result in exact wide arithmetic.
`timescale 1ns / 1ps
module tb_depth_pixel_reprojection_unit;
    import dpr_pkg::*;

    typedef logic signed [127:0] wide_t;

    // Expected-result store with its own copy of the register file
    class reproj_scoreboard;
        logic [62:0] regs [REG_COUNT];
        res_t        expected_q [$];
        int          fail_count;

        function new();
            regs[REG_BP0]  = 63'd262144;
            regs[REG_BP1]  = 63'd549755813888;
            regs[REG_BP2]  = 63'd1152921504606846976;
            regs[REG_TRAN] = 63'd0;
            regs[REG_K0]   = 63'd256;
            regs[REG_K1]   = 63'd536870912;
            regs[REG_K2]   = 63'd1125899906842624;
            fail_count = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [62:0] data);
            if (idx != REG_NONE)
                regs[idx] = data;
        endfunction

        function wide_t field(logic [62:0] r, int k);
            logic signed [20:0] f;
            f = r[21*k +: 21];
            return wide_t'(f);
        endfunction

        function logic signed [31:0] sat32(wide_t x, inout logic sat);
            if (x > wide_t'(64'sd2147483647)) begin
                sat = 1'b1;
                return 32'sh7fffffff;
            end
            if (x < -wide_t'(64'sd2147483648)) begin
                sat = 1'b1;
                return 32'sh80000000;
            end
            return x[31:0];
        endfunction

        // n * 2^16 / d truncated toward zero, then clipped
        function logic signed [31:0] image_coord(wide_t n, wide_t d, inout logic sat);
            wide_t un;
            wide_t ud;
            wide_t mag;
            un = (n < 0) ? -n : n;
            ud = (d < 0) ? -d : d;
            if (d == 0) begin
                sat = 1'b1;
                return (n > 0) ? 32'sh7fffffff : ((n < 0) ? 32'sh80000000 : 32'sd0);
            end
            mag = (un <<< 16) / ud;
            return sat32(((n < 0) != (d < 0)) ? -mag : mag, sat);
        endfunction

        function void note_pixel(logic [11:0] col, logic [11:0] row,
                                 logic signed [31:0] depth);
            wide_t p [3];
            wide_t pt [3];
            wide_t ps [3];
            wide_t q [3];
            wide_t acc;
            logic  sat;
            res_t  r;
            r = '0;
            sat = 1'b0;
            p[0] = wide_t'({1'b0, col}) * wide_t'(depth);
            p[1] = wide_t'({1'b0, row}) * wide_t'(depth);
            p[2] = wide_t'(depth);
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int i = 0; i < 3; i++)
                    acc += field(regs[j], i) * p[i];
                pt[j] = (acc >>> 18) + field(regs[REG_TRAN], j) * 4;
            end
            if (depth > 0 && pt[2] > 0) begin
                for (int j = 0; j < 3; j++)
                    ps[j] = wide_t'(sat32(pt[j], sat));
                for (int j = 0; j < 3; j++) begin
                    q[j] = 0;
                    for (int i = 0; i < 3; i++)
                        q[j] += field(regs[4 + j], i) * ps[i];
                end
                r.ok = 1'b1;
                r.ix = image_coord(q[0], q[2], sat);
                r.iy = image_coord(q[1], q[2], sat);
                r.px = ps[0][31:0];
                r.py = ps[1][31:0];
                r.pz = ps[2][31:0];
                r.sat = sat;
            end
            expected_q.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h expected %h", what, got, want);
            fail_count++;
        endtask

        task check_result(logic [159:0] data, logic [1:0] user);
            res_t e;
            if (expected_q.size() == 0) begin
                report("unexpected result", data[31:0], 32'd0);
                return;
            end
            e = expected_q.pop_front();
            if (user[0] !== e.ok)        report("valid_res", 32'(user[0]), 32'(e.ok));
            if (data[31:0] !== e.ix)     report("image_x", data[31:0], e.ix);
            if (data[63:32] !== e.iy)    report("image_y", data[63:32], e.iy);
            if (data[95:64] !== e.px)    report("point_x", data[95:64], e.px);
            if (data[127:96] !== e.py)   report("point_y", data[127:96], e.py);
            if (data[159:128] !== e.pz)  report("point_z", data[159:128], e.pz);
            if (user[1] !== e.sat)       report("saturated", 32'(user[1]), 32'(e.sat));
        endtask
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [55:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [159:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [62:0]  cfg_data = '0;

    logic quiet = 1'b0;
    int   stall_left = 0;
    reproj_scoreboard sb = new();

    depth_pixel_reprojection_unit i_dut (.*);

    always #5 clk = ~clk;

    // Watchdog
    initial
    begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Sample accepted requests and results
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_pixel(s_axis_tdata[11:0], s_axis_tdata[23:12], s_axis_tdata[55:24]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Output back-pressure in short bursts
    always @(negedge clk)
    begin
        if (quiet) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_pixel(logic [11:0] col, logic [11:0] row, logic [31:0] depth);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {depth, row, col};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [62:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every expected result has come out, then past the pipeline depth
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() > 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic logic [62:0] pack_row(int a, int b, int c);
        logic [20:0] fa;
        logic [20:0] fb;
        logic [20:0] fc;
        fa = a[20:0];
        fb = b[20:0];
        fc = c[20:0];
        return {fc, fb, fa};
    endfunction

    function automatic int srand(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // Program one full register set; kind picks the flavor of setting
    task automatic configure(int kind);
        logic [62:0] r [REG_COUNT];
        for (int i = 0; i < REG_COUNT; i++)
            r[i] = 63'({$urandom, $urandom});
        case (kind)
            0: begin  // identity transform, degenerate projection row
                r[REG_BP0] = pack_row(1 << 18, 0, 0);
                r[REG_BP1] = pack_row(0, 1 << 18, 0);
                r[REG_BP2] = pack_row(0, 0, 1 << 18);
                r[REG_TRAN] = pack_row(srand(4000), srand(4000), srand(4000));
                r[REG_K0] = pack_row(256, 0, 0);
                r[REG_K1] = pack_row(0, 256, 0);
                r[REG_K2] = '0;
            end
            1: for (int i = 0; i < REG_COUNT; i++) r[i] = pack_row(20'hfffff, 20'hfffff, 20'hfffff);
            2: for (int i = 0; i < REG_COUNT; i++) r[i] = pack_row(-(1 << 20), -(1 << 20), -(1 << 20));
            3: ; // fully random
            default: begin  // camera-like setting
                r[REG_BP0] = pack_row(srand(1 << 15), srand(1 << 12), srand(1 << 15));
                r[REG_BP1] = pack_row(srand(1 << 12), srand(1 << 15), srand(1 << 15));
                r[REG_BP2] = pack_row(srand(1 << 10), srand(1 << 10), (1 << 18) + srand(1 << 16));
                r[REG_TRAN] = pack_row(srand(1 << 16), srand(1 << 16), srand(1 << 15));
                r[REG_K0] = pack_row($urandom_range(1 << 16, 1 << 17), 0,
                                     $urandom_range(0, 1 << 19));
                r[REG_K1] = pack_row(0, $urandom_range(1 << 16, 1 << 17),
                                     $urandom_range(0, 1 << 19));
                r[REG_K2] = pack_row(srand(4), srand(4), 256);
            end
        endcase
        write_reg(REG_NONE, 63'({$urandom, $urandom}));
        for (int i = 0; i < REG_COUNT; i++)
            write_reg(reg_idx_t'(i), r[i]);
    endtask

    task automatic random_pixel();
        logic [31:0] depth;
        case ($urandom_range(0, 3))
            0: depth = $urandom;
            1: depth = $urandom_range(1, 1 << 16);
            default: depth = $urandom_range(1, 1 << 22);
        endcase
        send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), depth);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset registers: zero, negative and extreme depths, frame corners
        send_pixel(12'd0, 12'd0, 32'd0);
        send_pixel(12'd1, 12'd1, 32'hffffffff);
        send_pixel(12'd0, 12'd0, 32'h80000000);
        send_pixel(12'd4095, 12'd4095, 32'h00010000);
        send_pixel(12'd4095, 12'd0, 32'h7fffffff);
        send_pixel(12'd0, 12'd4095, 32'h7fffffff);
        send_pixel(12'd10, 12'd20, 32'd1);
        send_pixel(12'd0, 12'd7, 32'h00020000);
        drain();

        // Zero projected denominator
        configure(0);
        send_pixel(12'd0, 12'd0, 32'd1);
        send_pixel(12'd5, 12'd0, 32'h00010000);
        send_pixel(12'd4095, 12'd4095, 32'h7fffffff);
        send_pixel(12'd3, 12'd9, 32'h80000000);
        for (int i = 0; i < 10; i++) random_pixel();
        drain();

        // Coefficient extremes
        configure(1);
        for (int i = 0; i < 60; i++) random_pixel();
        drain();
        configure(2);
        for (int i = 0; i < 60; i++) random_pixel();
        drain();

        // Random and camera-like settings
        for (int ph = 0; ph < 8; ph++) begin
            configure((ph % 4 == 1) ? 3 : 4);
            if (ph == 7)
                quiet = 1'b1;
            for (int i = 0; i < 220; i++) random_pixel();
            drain();
        end

        if (sb.fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/dpr_pkg.sv
sv/dpr_divider.sv
sv/dpr_transform.sv
sv/depth_pixel_reprojection_unit.sv
sim/tb_depth_pixel_reprojection_unit.sv
